[design/ucf_pkg.sv]
// Shared types and constants for the UTF-8 case-fold token filter.
// No dependencies; used by the front decoder, the job queue and the back serializer.
`default_nettype none

package ucf_pkg;

  localparam logic [7:0] SPACE_BYTE = 8'h20;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  // One decoded input word: nsp spaces, then up to two token bytes.
  // cnt is the total number of result words (1..4).
  typedef struct packed {
    logic [2:0] cnt;
    logic [1:0] nsp;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       last;
  } job_t;

endpackage

`default_nettype wire

[design/ucf_front.sv]
// Front part: UTF-8 decode, case fold and classification into jobs.
// Depends on ucf_pkg (job_t, SPACE_BYTE).
`default_nettype none

module ucf_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output      logic          in_ready,
  input  wire logic [7:0]    in_byte,
  input  wire logic          in_last,
  input  wire logic          q_full,
  output      logic          push,
  output      ucf_pkg::job_t push_job
);

  typedef struct packed {
    logic [1:0] n;
    logic [7:0] b0;
    logic [7:0] b1;
  } emit_t;

  // Lowercase a code point and pick its output bytes.
  function automatic emit_t ucf_emit(input logic [20:0] cp_in);
    logic [20:0] cp;
    emit_t       e;
    cp = cp_in;
    if (cp >= 21'h41 && cp <= 21'h5A) begin
      cp = cp + 21'h20;
    end else if (cp >= 21'h410 && cp <= 21'h42F) begin
      cp = cp + 21'h20;
    end else if (cp == 21'h401) begin
      cp = 21'h451;
    end
    if ((cp >= 21'h30 && cp <= 21'h39) || (cp >= 21'h61 && cp <= 21'h7A)) begin
      e.n  = 2'd1;
      e.b0 = cp[7:0];
      e.b1 = ucf_pkg::SPACE_BYTE;
    end else if ((cp >= 21'h430 && cp <= 21'h44F) || cp == 21'h451) begin
      e.n  = 2'd2;
      e.b0 = {3'b110, cp[10:6]};
      e.b1 = {2'b10, cp[5:0]};
    end else begin
      e.n  = 2'd1;
      e.b0 = ucf_pkg::SPACE_BYTE;
      e.b1 = ucf_pkg::SPACE_BYTE;
    end
    return e;
  endfunction

  logic [1:0]  needed_r, needed_nxt;
  logic [1:0]  count_r, count_nxt;
  logic [20:0] accum_r, accum_nxt;

  logic        accept;
  logic        is_cont;
  logic [1:0]  cnt_inc;
  logic [20:0] acc_sh;
  logic        lead_go;
  logic [1:0]  nsp;
  emit_t       tail;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_cont  = (in_byte[7:6] == 2'b10);
  assign cnt_inc  = count_r + 2'd1;
  assign acc_sh   = {accum_r[14:0], in_byte[5:0]};

  always_comb begin
    needed_nxt = needed_r;
    count_nxt  = count_r;
    accum_nxt  = accum_r;
    nsp        = 2'd0;
    tail       = '{n: 2'd0, b0: ucf_pkg::SPACE_BYTE, b1: ucf_pkg::SPACE_BYTE};
    lead_go    = 1'b0;

    if (needed_r != 2'd0) begin
      if (is_cont) begin
        if (cnt_inc == needed_r) begin
          tail       = ucf_emit(acc_sh);
          needed_nxt = 2'd0;
          count_nxt  = 2'd0;
          accum_nxt  = '0;
        end else if (in_last) begin
          // truncated: one space for the lead and each continuation so far
          nsp = cnt_inc + 2'd1;
        end else begin
          count_nxt = cnt_inc;
          accum_nxt = acc_sh;
        end
      end else begin
        // broken sequence: spill held bytes, then treat this one as a lead
        nsp        = count_r + 2'd1;
        needed_nxt = 2'd0;
        count_nxt  = 2'd0;
        accum_nxt  = '0;
        lead_go    = 1'b1;
      end
    end else begin
      lead_go = 1'b1;
    end

    if (lead_go) begin
      priority if (!in_byte[7]) begin
        tail = ucf_emit({13'd0, in_byte});
      end else if (in_byte[7:5] == 3'b110 || in_byte[7:4] == 4'b1110 ||
                   in_byte[7:3] == 5'b11110) begin
        if (in_last) begin
          tail.n = 2'd1;
        end else begin
          count_nxt = 2'd0;
          priority if (in_byte[7:5] == 3'b110) begin
            needed_nxt = 2'd1;
            accum_nxt  = {16'd0, in_byte[4:0]};
          end else if (in_byte[7:4] == 4'b1110) begin
            needed_nxt = 2'd2;
            accum_nxt  = {17'd0, in_byte[3:0]};
          end else begin
            needed_nxt = 2'd3;
            accum_nxt  = {18'd0, in_byte[2:0]};
          end
        end
      end else begin
        tail.n = 2'd1;
      end
    end

    if (in_last) begin
      needed_nxt = 2'd0;
      count_nxt  = 2'd0;
      accum_nxt  = '0;
    end
  end

  always_comb begin
    push_job.cnt  = {1'b0, nsp} + {1'b0, tail.n};
    push_job.nsp  = nsp;
    push_job.b0   = tail.b0;
    push_job.b1   = tail.b1;
    push_job.last = in_last;
  end

  // drop words that produce nothing
  assign push = accept && (push_job.cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needed_r <= 2'd0;
      count_r  <= 2'd0;
      accum_r  <= '0;
    end else if (accept) begin
      needed_r <= needed_nxt;
      count_r  <= count_nxt;
      accum_r  <= accum_nxt;
    end
  end

endmodule

`default_nettype wire

[design/ucf_queue.sv]
// Short job queue between the front decoder and the back serializer.
// Depends on ucf_pkg (job_t, QUEUE_DEPTH and pointer widths).
`default_nettype none

module ucf_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire ucf_pkg::job_t push_job,
  output      logic          full,
  output      logic          head_valid,
  output      ucf_pkg::job_t head_job,
  input  wire logic          pop
);

  ucf_pkg::job_t                   slot_r [ucf_pkg::QUEUE_DEPTH];
  logic [ucf_pkg::QPTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [ucf_pkg::QFILL_W-1:0]     fill_r;

  assign full       = (fill_r == ucf_pkg::QFILL_W'(ucf_pkg::QUEUE_DEPTH));
  assign head_valid = (fill_r != '0);
  assign head_job   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   fill_r <= fill_r + 1'b1;
        2'b01:   fill_r <= fill_r - 1'b1;
        default: fill_r <= fill_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

[design/ucf_back.sv]
// Back part: serializes the queue head job into result words, one per cycle while out_ready allows.
// Depends on ucf_pkg (job_t, SPACE_BYTE).
`default_nettype none

module ucf_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          head_valid,
  input  wire ucf_pkg::job_t head_job,
  output      logic          pop,
  output      logic          out_valid,
  input  wire logic          out_ready,
  output      logic [7:0]    out_byte,
  output      logic          out_last
);

  logic [1:0] idx_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;

  logic       load;
  logic       take;
  logic       at_end;
  logic [7:0] sel_byte;

  assign load   = !out_valid_r || out_ready;
  assign take   = load && head_valid;
  assign at_end = ({1'b0, idx_r} == (head_job.cnt - 3'd1));
  assign pop    = take && at_end;

  always_comb begin
    priority if (idx_r < head_job.nsp) begin
      sel_byte = ucf_pkg::SPACE_BYTE;
    end else if (idx_r == head_job.nsp) begin
      sel_byte = head_job.b0;
    end else begin
      sel_byte = head_job.b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (load) begin
      out_valid_r <= head_valid;
      if (head_valid) begin
        idx_r <= at_end ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte_r <= sel_byte;
      out_last_r <= head_job.last && at_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

[design/utf8_case_fold_token_filter.sv]
// Top level of the UTF-8 case-fold token filter: front decoder, job queue, back serializer.
// Depends on ucf_pkg, ucf_front, ucf_queue and ucf_back.
//
//   channel  ports                          direction  word
//   in       in_valid in_ready in_byte in_last   in    one raw UTF-8 byte
//   out      out_valid out_ready out_byte out_last out one normalized byte
//
// The front takes one byte per cycle while the four-entry job queue has room.
// The back sends one result byte per cycle while out_ready is high; a byte that yields up to four
// results holds the queue head until its last result is taken.
// A result passes from its accepted byte through a queue slot and then the output register.
// Synchronous active-low reset clears decode state, queue and output register.
`default_nettype none

module utf8_case_fold_token_filter (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      logic [7:0] out_byte,
  output      logic       out_last
);

  logic          q_full;
  logic          push;
  ucf_pkg::job_t push_job;
  logic          head_valid;
  ucf_pkg::job_t head_job;
  logic          pop;

  ucf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  ucf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  ucf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .out_last   (out_last)
  );

endmodule

`default_nettype wire

[design/ucf_checker.sv]
// Port-level checks for the UTF-8 case-fold token filter, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module ucf_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [7:0] in_byte,
  input wire logic       in_last,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_last
);

  // output register is empty right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a waiting input word holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_byte) && $stable(in_last))
    else $error("input word changed while waiting");

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("output word changed while stalled");

  // only spaces, digits, lowercase letters and Cyrillic two-byte forms leave
  a_out_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte == 8'h20) ||
                  (out_byte >= 8'h30 && out_byte <= 8'h39) ||
                  (out_byte >= 8'h61 && out_byte <= 8'h7A) ||
                  (out_byte == 8'hD0) || (out_byte == 8'hD1) ||
                  (out_byte >= 8'h80 && out_byte <= 8'hBF))
    else $error("illegal output byte");

  // a Cyrillic lead is followed at once by its continuation and never ends a string
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_byte == 8'hD0 || out_byte == 8'hD1)
    |-> !out_last ##1 out_valid && (out_byte[7:6] == 2'b10))
    else $error("Cyrillic pair split");

endmodule

bind utf8_case_fold_token_filter ucf_checker u_ucf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_byte   (in_byte),
  .in_last   (in_last),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_byte  (out_byte),
  .out_last  (out_last)
);

`default_nettype wire

[tb/sv/utf8_case_fold_token_filter_tb.sv]
// Self-checking bench for utf8_case_fold_token_filter: directed and random byte strings.
// Depends on ucf_pkg (SPACE_BYTE) and the RTL top; a scoreboard class predicts each word.
`default_nettype none

module utf8_case_fold_token_filter_tb;

  localparam bit [20:0] CYR_UPPER_LO = 21'h0410;
  localparam bit [20:0] CYR_UPPER_HI = 21'h042F;
  localparam bit [20:0] CYR_LOWER_LO = 21'h0430;
  localparam bit [20:0] CYR_LOWER_HI = 21'h044F;
  localparam bit [20:0] CYR_IO_UPPER = 21'h0401;
  localparam bit [20:0] CYR_IO_LOWER = 21'h0451;
  localparam int RANDOM_ITEMS = 380;
  localparam int END_SETTLE = 12;
  localparam int RUN_LIMIT_CYCLES = 200000;

  class fold_scoreboard;
    typedef struct {
      logic [7:0] b;
      logic       l;
    } out_word_t;

    out_word_t  expected_q[$];
    bit   [7:0] step_q[$];
    int         errors;
    bit   [7:0] held_lead;
    bit   [1:0] held_needed;
    bit   [1:0] held_count;
    bit  [20:0] code_accum;

    function new();
      errors = 0;
      clear_held();
    endfunction

    function void clear_held();
      held_lead   = '0;
      held_needed = '0;
      held_count  = '0;
      code_accum  = '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Cap the words of one input byte at four.
    function void put_byte(bit [7:0] b);
      if (step_q.size() < 4) step_q.insert(step_q.size(), b);
    endfunction

    function void fold_code(bit [20:0] cp);
      if (cp >= 21'h41 && cp <= 21'h5A) begin
        cp = cp + 21'd32;
      end else if (cp >= CYR_UPPER_LO && cp <= CYR_UPPER_HI) begin
        cp = cp + 21'h20;
      end else if (cp == CYR_IO_UPPER) begin
        cp = CYR_IO_LOWER;
      end
      if ((cp >= 21'h30 && cp <= 21'h39) || (cp >= 21'h61 && cp <= 21'h7A)) begin
        put_byte(cp[7:0]);
      end else if ((cp >= CYR_LOWER_LO && cp <= CYR_LOWER_HI) || cp == CYR_IO_LOWER) begin
        put_byte({3'b110, cp[10:6]});
        put_byte({2'b10, cp[5:0]});
      end else begin
        put_byte(ucf_pkg::SPACE_BYTE);
      end
    endfunction

    function void take_lead(bit [7:0] b, bit last);
      bit  [1:0] need;
      bit [20:0] bits;
      if (!b[7]) begin
        fold_code({13'd0, b});
        return;
      end
      if (b[7:5] == 3'b110) begin
        need = 2'd1;
        bits = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        need = 2'd2;
        bits = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        need = 2'd3;
        bits = {18'd0, b[2:0]};
      end else begin
        put_byte(ucf_pkg::SPACE_BYTE);
        return;
      end
      if (last) begin
        put_byte(ucf_pkg::SPACE_BYTE);
        return;
      end
      held_lead   = b;
      held_needed = need;
      held_count  = '0;
      code_accum  = bits;
    endfunction

    // One space for the lead and one for each held continuation.
    function void spill();
      repeat (1 + held_count) put_byte(ucf_pkg::SPACE_BYTE);
      clear_held();
    endfunction

    function void note_input(bit [7:0] b, bit last);
      bit [20:0] cp;
      out_word_t w;
      step_q.delete();
      if (held_needed != 0) begin
        if (b[7:6] == 2'b10) begin
          code_accum = {code_accum[14:0], b[5:0]};
          held_count = held_count + 2'd1;
          if (held_count == held_needed) begin
            cp = code_accum;
            clear_held();
            fold_code(cp);
          end else if (last) begin
            spill();
          end
        end else begin
          spill();
          take_lead(b, last);
        end
      end else begin
        take_lead(b, last);
      end
      if (last) clear_held();
      foreach (step_q[i]) begin
        w.b = step_q[i];
        w.l = last && (i == step_q.size() - 1);
        expected_q.insert(expected_q.size(), w);
      end
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(logic [7:0] b, logic l);
      out_word_t w;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected word byte=%02h last=%b", b, l));
      end else begin
        w = expected_q.pop_front();
        if (w.b !== b) report($sformatf("byte got %02h want %02h", b, w.b));
        if (w.l !== l) report($sformatf("last got %b want %b (byte %02h)", l, w.l, w.b));
      end
    endtask

    task check_drained();
      if (expected_q.size() != 0)
        report($sformatf("%0d words never arrived", expected_q.size()));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;

  fold_scoreboard sb = new();
  int idle_pct = 6;
  int bytes_sent = 0;

  utf8_case_fold_token_filter u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .out_last (out_last)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= idle_pct);
  end

  // Sample both channels on the edge; inputs are noted before results.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_byte, in_last);
      if (out_valid && out_ready) sb.check_result(out_byte, out_last);
    end
  end

  task automatic send_word(bit [7:0] b, bit l);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  function automatic bit [7:0] rand_cont();
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  function automatic bit [7:0] rand_lead(int need);
    case (need)
      1: return 8'hC0 | 8'($urandom_range(31));
      2: return 8'hE0 | 8'($urandom_range(15));
      default: return 8'hF0 | 8'($urandom_range(7));
    endcase
  endfunction

  // Mostly well-formed sequences; the rest noise, broken and truncated ones.
  task automatic send_random_chunk();
    bit [7:0] seq[$];
    int kind;
    int need;
    bit end_str;
    kind = $urandom_range(99);
    if (kind < 28) begin
      seq.insert(seq.size(), 8'($urandom_range(127)));
    end else if (kind < 44) begin
      seq.insert(seq.size(), $urandom_range(1) ? 8'hD0 : 8'hD1);
      seq.insert(seq.size(), rand_cont());
    end else if (kind < 54) begin
      seq.insert(seq.size(), rand_lead(1));
      seq.insert(seq.size(), rand_cont());
    end else if (kind < 62) begin
      seq.insert(seq.size(), rand_lead(2));
      repeat (2) seq.insert(seq.size(), rand_cont());
    end else if (kind < 70) begin
      seq.insert(seq.size(), rand_lead(3));
      repeat (3) seq.insert(seq.size(), rand_cont());
    end else if (kind < 84) begin
      seq.insert(seq.size(), 8'($urandom_range(255)));
    end else begin
      need = $urandom_range(3, 1);
      seq.insert(seq.size(), rand_lead(need));
      repeat ($urandom_range(need - 1)) seq.insert(seq.size(), rand_cont());
    end
    end_str = ($urandom_range(99) < 12);
    foreach (seq[i]) begin
      send_word(seq[i], (end_str && i == seq.size() - 1) || ($urandom_range(99) < 2));
    end
  endtask

  initial begin
    bit paused;
    paused = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Letters, digits, NUL, bad leads
    send_word(8'h41, 1'b0);
    send_word(8'h5A, 1'b0);
    send_word(8'h30, 1'b0);
    send_word(8'h39, 1'b0);
    send_word(8'h7A, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h80, 1'b1);
    // Cyrillic upper A and upper IO fold to lowercase
    send_word(8'hD0, 1'b0);
    send_word(8'h90, 1'b0);
    send_word(8'hD0, 1'b0);
    send_word(8'h81, 1'b0);
    // Four-byte lead broken by an ASCII letter
    send_word(8'hF0, 1'b0);
    send_word(8'h9F, 1'b0);
    send_word(8'h98, 1'b0);
    send_word(8'h41, 1'b0);
    // Overlong A
    send_word(8'hC1, 1'b0);
    send_word(8'h81, 1'b0);
    // Truncated at end, then a lead at end
    send_word(8'hE2, 1'b0);
    send_word(8'h82, 1'b1);
    send_word(8'hC3, 1'b1);
    // Complete four-byte code point ending the string
    send_word(8'hF0, 1'b0);
    send_word(8'h90, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h80, 1'b1);

    while (bytes_sent < RANDOM_ITEMS) begin
      idle_pct = (bytes_sent >= 120 && bytes_sent < 240) ? 0 : 6;
      // Hold the sender until every word so far has come out.
      if (!paused && bytes_sent >= 300) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end
      send_random_chunk();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (END_SETTLE) @(posedge clk);
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("utf8_case_fold_token_filter verification clean");
    end else begin
      $display("utf8_case_fold_token_filter verification failed");
    end
    $finish;
  end

  initial begin
    #(12 * RUN_LIMIT_CYCLES);
    $display("utf8_case_fold_token_filter verification failed");
    $finish;
  end

endmodule

`default_nettype wire
